[sv/bjmc_pkg.sv]
// Shared types and constants for the bounded-jump minimum-cost chain.
// No dependencies; used by bjmc_cell and bounded_jump_min_cost_dp.
`default_nettype none

package bjmc_pkg;

    localparam int DUR_W        = 16;
    localparam int COST_W       = 32;
    localparam int JL_W         = 5;
    localparam int MAX_JUMP_DEF = 16;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = APB_ADDR_W - 2;

    localparam logic [COST_W-1:0]    COST_MAX       = '1;
    localparam logic [JL_W-1:0]      JUMP_LIMIT_RST = JL_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_JUMP_LIMIT = '0;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             is_last;
    } in_beat_t;

    typedef struct packed {
        logic [COST_W-1:0] min_cost;
        logic              final_flag;
    } out_beat_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             calc;
        logic             shift;
        logic [DUR_W-1:0] duration;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/bounded_jump_min_cost_dp.sv]
// Bounded-jump minimum-cost chain: top level with sequencer, APB register,
// result register and a row of MAX_JUMP history cells. Depends on bjmc_pkg, bjmc_cell.
// A new input beat is taken only after the previous result is registered, as the running
// minimum ripples one cell per cycle down the row; a result waiting on m_ready stalls the sequencer.
// Reset (synchronous, aresetn low): history empty, jump_limit = 1, no result held.
`default_nettype none

module bounded_jump_min_cost_dp
    import bjmc_pkg::*;
#(
    parameter int MAX_JUMP = MAX_JUMP_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_beat_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_beat_t                  m_data
);

    localparam int CNT_W = $clog2(MAX_JUMP + 1);
    localparam int LIM_W = (CNT_W > JL_W) ? CNT_W : JL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MIN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  hist_reg, hist_next;
    logic [JL_W-1:0]   jl_reg;
    logic [DUR_W-1:0]  cur_dur_reg;
    logic              cur_last_reg;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         out_reg;

    logic              s_accept;
    logic              done_fire;
    logic              reg_sel;
    logic [LIM_W-1:0]  jl_ext, lim_ext;
    logic [CNT_W-1:0]  lim, span;
    logic [COST_W-1:0] result_cost;
    cell_ctrl_t        ctrl;

    logic [DUR_W-1:0]  dur_chain  [MAX_JUMP+1];
    logic [COST_W-1:0] cost_chain [MAX_JUMP+1];
    logic [COST_W-1:0] min_chain  [MAX_JUMP+1];

    // APB register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_JUMP_LIMIT);
    assign prdata  = reg_sel ? APB_DATA_W'(jl_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jl_reg <= JUMP_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            jl_reg <= pwdata[JL_W-1:0];
        end
    end

    // Effective jump span: clamp limit to 1..MAX_JUMP, then to history held
    always_comb begin
        jl_ext = LIM_W'(jl_reg);
        if (jl_ext == '0) begin
            lim_ext = LIM_W'(1);
        end else if (jl_ext > LIM_W'(MAX_JUMP)) begin
            lim_ext = LIM_W'(MAX_JUMP);
        end else begin
            lim_ext = jl_ext;
        end
        lim  = CNT_W'(lim_ext);
        span = (lim < hist_reg) ? lim : hist_reg;
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign s_accept    = s_valid && s_ready;
    assign done_fire   = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign result_cost = (hist_reg == '0) ? '0 : min_chain[MAX_JUMP];

    always_comb begin
        ctrl.calc     = s_accept;
        ctrl.shift    = done_fire && !cur_last_reg;
        ctrl.duration = s_data.duration;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        hist_next    = hist_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                cnt_next = '0;
                if (s_accept) begin
                    state_next = S_MIN;
                end
            end
            S_MIN: begin
                // let the minimum ripple through every cell
                if (cnt_reg == CNT_W'(MAX_JUMP - 1)) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (done_fire) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    if (cur_last_reg) begin
                        hist_next = '0;
                    end else if (hist_reg < CNT_W'(MAX_JUMP)) begin
                        hist_next = hist_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            hist_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            hist_reg    <= hist_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cur_dur_reg  <= s_data.duration;
            cur_last_reg <= s_data.is_last;
        end
        if (done_fire) begin
            out_reg.min_cost   <= result_cost;
            out_reg.final_flag <= cur_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Head of the row: newest item enters on shift, minimum starts at the top
    assign dur_chain[0]  = cur_dur_reg;
    assign cost_chain[0] = result_cost;
    assign min_chain[0]  = COST_MAX;

    for (genvar k = 0; k < MAX_JUMP; k++) begin : g_cell
        bjmc_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .span      (span),
            .prev_dur  (dur_chain[k]),
            .prev_cost (cost_chain[k]),
            .prev_min  (min_chain[k]),
            .dur_out   (dur_chain[k+1]),
            .cost_out  (cost_chain[k+1]),
            .min_out   (min_chain[k+1])
        );
    end

endmodule

`default_nettype wire

[sv/bjmc_cell.sv]
// One history cell: holds a past duration and its cost, forms the jump
// candidate and passes history and a running minimum to its neighbor.
// Depends on bjmc_pkg.
`default_nettype none

module bjmc_cell
    import bjmc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic              aclk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [CNT_W-1:0]  span,
    input  wire logic [DUR_W-1:0]  prev_dur,
    input  wire logic [COST_W-1:0] prev_cost,
    input  wire logic [COST_W-1:0] prev_min,
    output logic      [DUR_W-1:0]  dur_out,
    output logic      [COST_W-1:0] cost_out,
    output logic      [COST_W-1:0] min_out
);

    logic [DUR_W-1:0]  pd_reg;
    logic [COST_W-1:0] pc_reg;
    logic [COST_W-1:0] cand_reg;
    logic [COST_W-1:0] cand_next;
    logic [COST_W-1:0] min_reg;
    logic [DUR_W-1:0]  diff;
    logic [COST_W:0]   sum;

    always_comb begin
        diff = (ctrl.duration >= pd_reg) ? ctrl.duration - pd_reg : pd_reg - ctrl.duration;
        sum  = {1'b0, pc_reg} + (COST_W + 1)'(diff);
        if (CNT_W'(IDX) >= span) begin
            cand_next = COST_MAX;
        end else if (sum[COST_W]) begin
            cand_next = COST_MAX;
        end else begin
            cand_next = sum[COST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.calc) begin
            cand_reg <= cand_next;
        end
        if (ctrl.shift) begin
            pd_reg <= prev_dur;
            pc_reg <= prev_cost;
        end
        // fold own candidate into the minimum arriving from the left
        min_reg <= (prev_min < cand_reg) ? prev_min : cand_reg;
    end

    assign dur_out  = pd_reg;
    assign cost_out = pc_reg;
    assign min_out  = min_reg;

endmodule

`default_nettype wire
